// ===== sv/hash_bucket_table_macros.svh =====
// Assertion helpers shared by the checker. Each expects clk and arst_n in scope.
`ifndef HASH_BUCKET_TABLE_MACROS_SVH
`define HASH_BUCKET_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HBT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define HBT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hbt_pkg.sv =====
package hbt_pkg;

	localparam int BUCKETS_DEF      = 10;
	localparam int BUCKET_DEPTH_DEF = 4;

	localparam int KEY_W = 31;
	localparam int BKT_W = 4;
	localparam int IDX_W = 2;
	localparam int CNT_W = 3;

	typedef logic [1:0] status_t;

	localparam status_t ST_STORED = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_ENTRY  = 2'd2;
	localparam status_t ST_EMPTY  = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DUMP   = 1'b1;

	// One access to the key store: bucket row and slot within the row.
	typedef struct packed {
		logic             en;
		logic [BKT_W-1:0] bkt;
		logic [IDX_W-1:0] idx;
	} mem_acc_t;

endpackage

// ===== sv/hbt_hash.sv =====
module hbt_hash #(
	parameter int BUCKETS = hbt_pkg::BUCKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_v,
	input  logic [hbt_pkg::KEY_W-1:0] key,
	output logic                      v_s2,
	output logic [hbt_pkg::KEY_W-1:0] key_s2,
	output logic [hbt_pkg::BKT_W-1:0] bkt_s2,
	output logic                      pending
);

	// residue weights of each nibble position: 16^n mod BUCKETS
	logic [3:0]                wt   [8];
	logic [3:0]                nib  [8];
	logic [7:0]                prod [8];
	logic [hbt_pkg::BKT_W-1:0] rtab [256];
	logic [31:0]               key_ext;
	logic [10:0]               sum_c;
	logic [8:0]                f2;
	logic [7:0]                f3;
	logic                      v_s1;
	logic [hbt_pkg::KEY_W-1:0] key_s1;
	logic [10:0]               sum_s1;

	assign key_ext = {1'b0, key};

	for (genvar g = 0; g < 8; g++) begin : g_nib
		localparam int WI = (1 << (4 * g)) % BUCKETS;
		assign wt[g]   = 4'(WI);
		assign nib[g]  = key_ext[4*g +: 4];
		assign prod[g] = {4'd0, nib[g]} * {4'd0, wt[g]};
	end

	for (genvar g = 0; g < 256; g++) begin : g_rtab
		localparam int RI = g % BUCKETS;
		assign rtab[g] = hbt_pkg::BKT_W'(RI);
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < 8; k++) begin
			sum_c = sum_c + 11'(prod[k]);
		end
	end

	// fold the 11-bit residue sum twice down to 8 bits, then look up the remainder
	assign f2 = 9'(sum_s1[3:0]) * 9'(wt[0]) + 9'(sum_s1[7:4]) * 9'(wt[1])
		+ 9'(sum_s1[10:8]) * 9'(wt[2]);
	assign f3 = 8'(f2[3:0]) * 8'(wt[0]) + 8'(f2[7:4]) * 8'(wt[1])
		+ 8'(f2[8]) * 8'(wt[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= key;
		sum_s1 <= sum_c;
		key_s2 <= key_s1;
		bkt_s2 <= rtab[f3];
	end

	assign pending = v_s1 | v_s2;

endmodule

// ===== sv/hbt_store.sv =====
module hbt_store #(
	parameter int BUCKETS = hbt_pkg::BUCKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hbt_pkg::mem_acc_t         wr,
	input  logic [hbt_pkg::KEY_W-1:0] wdata,
	input  hbt_pkg::mem_acc_t         rd,
	output logic [hbt_pkg::KEY_W-1:0] rdata_s1,
	input  logic [hbt_pkg::BKT_W-1:0] fidx,
	output logic [hbt_pkg::CNT_W-1:0] fill
);

	localparam int BIW  = $clog2(BUCKETS);
	localparam int AW   = BIW + hbt_pkg::IDX_W;
	localparam int ROWS = BUCKETS << hbt_pkg::IDX_W;

	logic [hbt_pkg::KEY_W-1:0] mem    [ROWS];
	logic [hbt_pkg::CNT_W-1:0] fill_q [BUCKETS];
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;

	assign waddr = {wr.bkt[BIW-1:0], wr.idx};
	assign raddr = {rd.bkt[BIW-1:0], rd.idx};
	assign fill  = fill_q[fidx[BIW-1:0]];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wdata;
		end
		if (rd.en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// advance the count of the row just written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < BUCKETS; i++) begin
				if (wr.en && wr.bkt[BIW-1:0] == BIW'(i)) begin
					fill_q[i] <= fill_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/hash_bucket_table.sv =====
// Channel  | Handshake               | Word
// ---------+-------------------------+---------------------------------
// command  | start && !busy          | action, key
// result   | valid (one cycle)       | status, value, bucket, last
//
// Inserts may follow each other every cycle while busy is low; each result passes
// the hash stages and is then registered onto the result port. A dump holds busy
// while it runs: drain the inserts still in the hash stages, one count test per
// bucket plus one read per stored key, then close. Reset clears the fill counts
// and the control and result registers, but not the key store.
// The receiver cannot stall; a result is valid for exactly one cycle.
module hash_bucket_table #(
	parameter int BUCKETS      = hbt_pkg::BUCKETS_DEF,
	parameter int BUCKET_DEPTH = hbt_pkg::BUCKET_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      action,
	input  logic [hbt_pkg::KEY_W-1:0] key,
	output logic                      valid,
	output hbt_pkg::status_t          status,
	output logic [hbt_pkg::KEY_W-1:0] value,
	output logic [hbt_pkg::BKT_W-1:0] bucket,
	output logic                      last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DRAIN,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic                      accept;
	logic                      h_v;
	logic [hbt_pkg::KEY_W-1:0] h_key;
	logic [hbt_pkg::BKT_W-1:0] h_bkt;
	logic                      h_pending;
	hbt_pkg::mem_acc_t         wr;
	hbt_pkg::mem_acc_t         rd;
	logic [hbt_pkg::KEY_W-1:0] rdata_s1;
	logic [hbt_pkg::BKT_W-1:0] fidx;
	logic [hbt_pkg::CNT_W-1:0] fill;
	logic                      full;
	logic                      hit;
	logic [hbt_pkg::BKT_W-1:0] scan_b_q;
	logic [hbt_pkg::CNT_W-1:0] scan_i_q;
	logic                      rd_s1;
	logic [hbt_pkg::BKT_W-1:0] rd_b_s1;
	logic                      pend_v_q;
	logic [hbt_pkg::KEY_W-1:0] pend_val_q;
	logic [hbt_pkg::BKT_W-1:0] pend_b_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	// bucket = key mod BUCKETS, two stages
	hbt_hash #(
		.BUCKETS (BUCKETS)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (accept && action == hbt_pkg::ACT_INSERT),
		.key     (key),
		.v_s2    (h_v),
		.key_s2  (h_key),
		.bkt_s2  (h_bkt),
		.pending (h_pending)
	);

	// key rows plus per-bucket fill counts
	hbt_store #(
		.BUCKETS (BUCKETS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wdata    (h_key),
		.rd       (rd),
		.rdata_s1 (rdata_s1),
		.fidx     (fidx),
		.fill     (fill)
	);

	// The count port serves the insert stage, or the scan while dumping.
	// Inserts never sit in the hash stages during a scan, so the two never meet.
	always_comb begin
		fidx = (state_q == S_SCAN) ? scan_b_q : h_bkt;
		full = (fill >= hbt_pkg::CNT_W'(BUCKET_DEPTH));
		hit  = (state_q == S_SCAN) && (scan_i_q < fill);
		wr   = '{en: h_v & ~full, bkt: h_bkt, idx: fill[hbt_pkg::IDX_W-1:0]};
		rd   = '{en: hit, bkt: scan_b_q, idx: scan_i_q[hbt_pkg::IDX_W-1:0]};
	end

	// Dumped keys are held one word back in pend_*, so the final one can be
	// marked last once the scan has run out of rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_b_q   <= '0;
			scan_i_q   <= '0;
			rd_s1      <= 1'b0;
			rd_b_s1    <= '0;
			pend_v_q   <= 1'b0;
			pend_val_q <= '0;
			pend_b_q   <= '0;
			valid      <= 1'b0;
			status     <= hbt_pkg::ST_STORED;
			value      <= '0;
			bucket     <= '0;
			last       <= 1'b0;
		end else begin
			valid   <= 1'b0;
			rd_s1   <= rd.en;
			rd_b_s1 <= scan_b_q;

			priority if (h_v) begin
				// insert result: stored, or dropped on a full row
				valid  <= 1'b1;
				status <= full ? hbt_pkg::ST_FULL : hbt_pkg::ST_STORED;
				value  <= h_key;
				bucket <= h_bkt;
				last   <= 1'b1;
			end else if (rd_s1) begin
				// new key from the store: release the held one, hold the new one
				if (pend_v_q) begin
					valid  <= 1'b1;
					status <= hbt_pkg::ST_ENTRY;
					value  <= pend_val_q;
					bucket <= pend_b_q;
					last   <= 1'b0;
				end
				pend_v_q   <= 1'b1;
				pend_val_q <= rdata_s1;
				pend_b_q   <= rd_b_s1;
			end else if (state_q == S_FINISH) begin
				// close the dump: last held key, or the empty marker
				valid  <= 1'b1;
				last   <= 1'b1;
				if (pend_v_q) begin
					status <= hbt_pkg::ST_ENTRY;
					value  <= pend_val_q;
					bucket <= pend_b_q;
				end else begin
					status <= hbt_pkg::ST_EMPTY;
					value  <= '0;
					bucket <= '0;
				end
				pend_v_q <= 1'b0;
			end else begin
				// nothing to send: hold the result registers
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && action == hbt_pkg::ACT_DUMP) begin
						state_q  <= S_DRAIN;
						scan_b_q <= '0;
						scan_i_q <= '0;
					end
				end
				S_DRAIN: begin
					// let earlier inserts update their counts first
					if (!h_pending) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						scan_i_q <= scan_i_q + 1'b1;
					end else if (scan_b_q == hbt_pkg::BKT_W'(BUCKETS - 1)) begin
						state_q <= S_FINISH;
					end else begin
						scan_b_q <= scan_b_q + 1'b1;
						scan_i_q <= '0;
					end
				end
				S_FINISH: begin
					if (!rd_s1) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== sv/hbt_chk.sv =====
`include "hash_bucket_table_macros.svh"

module hbt_chk #(
	parameter int BUCKETS = hbt_pkg::BUCKETS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      action,
	input logic                      valid,
	input hbt_pkg::status_t          status,
	input logic [hbt_pkg::KEY_W-1:0] value,
	input logic [hbt_pkg::BKT_W-1:0] bucket,
	input logic                      last
);

	logic mid_word;
	logic entry_word;
	logic empty_word;
	logic blank_ok;
	logic insert_word;
	logic insert_ok;
	logic dump_take;

	assign mid_word    = valid && !last;
	assign entry_word  = (status == hbt_pkg::ST_ENTRY);
	assign empty_word  = valid && status == hbt_pkg::ST_EMPTY;
	assign blank_ok    = (value == '0) && (bucket == '0) && last;
	assign insert_word = valid && (status == hbt_pkg::ST_STORED || status == hbt_pkg::ST_FULL);
	assign insert_ok   = last && (int'(bucket) < BUCKETS);
	assign dump_take   = start && !busy && action == hbt_pkg::ACT_DUMP;

	// only dump entries come without last, and only while the dump runs
	`HBT_ASSERT_IMP(a_mid_entry, mid_word, entry_word && busy, "stray non-last word")

	`HBT_ASSERT_IMP(a_empty_word, empty_word, blank_ok, "malformed empty marker")

	`HBT_ASSERT_IMP(a_insert_word, insert_word, insert_ok, "malformed insert result")

	`HBT_ASSERT_NXT(a_dump_busy, dump_take, busy, "dump did not raise busy")

endmodule

bind hash_bucket_table hbt_chk #(.BUCKETS(BUCKETS)) u_hbt_chk (.*);
